// ----- rtl/ppwc_pkg.sv -----
// Package for the path point winding counter: item types, codes and states.
package ppwc_pkg;

    localparam int CFG_IDX_BITS = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Y = 2'd1;

    // Segment kinds.
    localparam logic [2:0] FN_MOVETO  = 3'd0;
    localparam logic [2:0] FN_LINETO  = 3'd1;
    localparam logic [2:0] FN_QUADTO  = 3'd2;
    localparam logic [2:0] FN_CUBICTO = 3'd3;
    localparam logic [2:0] FN_CLOSE   = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               last_segment;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] winding;
        logic               bad_start;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LINE,
        S_MUL,
        S_MRES,
        S_BOX,
        S_SPLIT1,
        S_SPLIT2,
        S_SPLIT3,
        S_NEXT,
        S_POP,
        S_COMMIT,
        S_TAIL,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/path_point_winding_counter.sv -----
// Top level of the path point winding counter: sequencer, line unit and curve stack.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready    | i_in  (t_in_item)
//  out     | out       | o_out_valid / i_out_ready  | o_out (t_out_item)
//
// Each exact line intercept runs the shared shift-add multiplier over both products and
// then reads the sign of the difference. Curves are halved (box test, three split steps)
// until the box test decides each piece; the next piece is then popped from the stack.
// At the deepest level each chord takes a line step and possibly an intercept.
// The input is not ready until the item is finished; a result waits in the output
// register while the next item is taken. Reset is synchronous and clears the path state
// and the test point.
module path_point_winding_counter
    import ppwc_pkg::*;
#(
    parameter int MAX_LEVEL  = 24,
    parameter int COORD_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out
);

    localparam int W      = COORD_BITS;
    localparam int EW     = (W > 32) ? W : 32;
    localparam int M      = W + 1;
    localparam int P      = 2 * M + 1;
    localparam int CW     = $clog2(2 * M);
    localparam int C      = COUNT_BITS;
    localparam int TW     = MAX_LEVEL + 3;
    localparam int LW     = $clog2(MAX_LEVEL + 2);
    localparam int FRAMES = MAX_LEVEL + 1;
    localparam int AW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW     = 8 * W + LW;
    localparam int SW0    = (C > TW) ? C : TW;
    localparam int SW     = ((SW0 > 16) ? SW0 : 16) + 1;
    localparam logic signed [SW-1:0] CNT_HI = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] CNT_LO = -CNT_HI - SW'(1);
    localparam logic signed [SW-1:0] OUT_HI = SW'(32767);
    localparam logic signed [SW-1:0] OUT_LO = -OUT_HI - SW'(1);

    function automatic logic signed [W-1:0] f_coord(input logic signed [31:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        return e[W-1:0];
    endfunction

    // Floor of the mean, as an arithmetic shift of the grown sum.
    function automatic logic signed [W-1:0] f_half(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        return s[W:1];
    endfunction

    t_state r_state, n_state;

    logic [31:0]          r_px32, r_py32;
    logic signed [W-1:0]  px, py;

    logic [2:0]           r_func;
    logic                 r_last;
    logic signed [W-1:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    logic                 r_started, n_started;
    logic                 r_err, n_err;
    logic signed [W-1:0]  r_mvx, n_mvx, r_mvy, n_mvy, r_cux, n_cux, r_cuy, n_cuy;
    logic signed [C-1:0]  r_count, n_count;
    logic signed [TW-1:0] r_tot, n_tot;
    logic                 r_final, n_final;
    logic                 r_chord, n_chord;

    logic signed [W-1:0]  r_lx0, n_lx0, r_ly0, n_ly0, r_lx1, n_lx1, r_ly1, n_ly1;
    logic signed [1:0]    r_dir, n_dir;
    logic                 r_dpos, n_dpos;
    logic signed [P-1:0]  r_ma, n_ma, r_acc, n_acc;
    logic [M-1:0]         r_mb, n_mb;
    logic signed [M-1:0]  r_mc, n_mc, r_me, n_me;
    logic [CW-1:0]        r_mcnt, n_mcnt;

    logic                 r_cubic, n_cubic;
    logic signed [W-1:0]  r_vx [4];
    logic signed [W-1:0]  n_vx [4];
    logic signed [W-1:0]  r_vy [4];
    logic signed [W-1:0]  n_vy [4];
    logic signed [W-1:0]  r_tx [5];
    logic signed [W-1:0]  n_tx [5];
    logic signed [W-1:0]  r_ty [5];
    logic signed [W-1:0]  n_ty [5];
    logic [LW-1:0]        r_lvl, n_lvl, r_sp, n_sp, sp_m1;

    logic [FW-1:0]        mem [FRAMES];
    logic [FW-1:0]        r_rd, push_frame;

    logic                 r_ovalid, n_ovalid;
    t_out_item            r_out, n_out;

    logic                 in_acc;
    logic signed [W-1:0]  end_x, end_y;
    logic                 all_below, all_above, all_right, all_left, box_done;
    logic signed [1:0]    box_r, line_r;
    logic                 line_quick;
    logic signed [P-1:0]  term;
    logic                 negate;
    logic signed [SW-1:0] cnt_sum, cnt_w;
    logic signed [C-1:0]  cnt_sat;
    logic signed [W-1:0]  mx, my;

    assign px = f_coord(r_px32);
    assign py = f_coord(r_py32);
    assign in_acc = i_in_valid && o_in_ready;
    assign sp_m1 = r_sp - LW'(1);

    // Box test over the control points of the current curve piece.
    always_comb begin
        all_below = 1'b1;
        all_above = 1'b1;
        all_right = 1'b1;
        all_left  = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (i < 3 || r_cubic) begin
                if (!(py < r_vy[i]))  all_below = 1'b0;
                if (!(py >= r_vy[i])) all_above = 1'b0;
                if (!(px >= r_vx[i])) all_right = 1'b0;
                if (!(px < r_vx[i]))  all_left  = 1'b0;
            end
        end
        end_x = r_cubic ? r_vx[3] : r_vx[2];
        end_y = r_cubic ? r_vy[3] : r_vy[2];
        box_done = all_below || all_above || all_right || all_left;
        box_r = 2'sd0;
        if (!(all_below || all_above || all_right) && all_left) begin
            if (py >= r_vy[0]) begin
                if (py < end_y) box_r = 2'sd1;
            end else if (py >= end_y) begin
                box_r = -2'sd1;
            end
        end
    end

    // Quick decisions of the line unit; the rest needs the exact product compare.
    always_comb begin
        line_quick = 1'b1;
        line_r     = 2'sd0;
        if (py < r_ly0 && py < r_ly1) begin
            line_r = 2'sd0;
        end else if (py >= r_ly0 && py >= r_ly1) begin
            line_r = 2'sd0;
        end else if (px >= r_lx0 && px >= r_lx1) begin
            line_r = 2'sd0;
        end else if (px < r_lx0 && px < r_lx1) begin
            line_r = (r_ly0 < r_ly1) ? 2'sd1 : -2'sd1;
        end else begin
            line_quick = 1'b0;
        end
    end

    always_comb begin
        term   = r_mb[0] ? r_ma : '0;
        // The top multiplier bit carries negative weight; the second product is subtracted.
        negate = ((r_mcnt == CW'(M - 1)) || (r_mcnt == CW'(2 * M - 1)))
                 ^ (r_mcnt >= CW'(M));
        cnt_sum = SW'(r_count) + SW'(r_tot);
        if (cnt_sum > CNT_HI)      cnt_sat = CNT_HI[C-1:0];
        else if (cnt_sum < CNT_LO) cnt_sat = CNT_LO[C-1:0];
        else                       cnt_sat = cnt_sum[C-1:0];
        cnt_w = SW'(r_count);
        mx = f_half(r_tx[3], r_tx[4]);
        my = f_half(r_ty[3], r_ty[4]);
        if (r_cubic) begin
            push_frame = {mx, r_tx[4], r_tx[2], r_vx[3], my, r_ty[4], r_ty[2], r_vy[3],
                          r_lvl + LW'(1)};
        end else begin
            push_frame = {mx, r_tx[4], r_vx[2], r_vx[3], my, r_ty[4], r_vy[2], r_vy[3],
                          r_lvl + LW'(1)};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_acc) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (!r_started) begin
                    n_state = S_TAIL;
                end else begin
                    case (r_func)
                        FN_MOVETO, FN_CLOSE: n_state = (r_cuy != r_mvy) ? S_LINE : S_COMMIT;
                        FN_LINETO:           n_state = S_LINE;
                        FN_QUADTO, FN_CUBICTO: n_state = S_BOX;
                        default:             n_state = S_TAIL;
                    endcase
                end
            end
            S_LINE: begin
                if (!line_quick)   n_state = S_MUL;
                else if (r_chord)  n_state = S_NEXT;
                else               n_state = S_COMMIT;
            end
            S_MUL:    if (r_mcnt == CW'(2 * M - 1)) n_state = S_MRES;
            S_MRES:   n_state = r_chord ? S_NEXT : S_COMMIT;
            S_BOX: begin
                if (box_done)                        n_state = S_NEXT;
                else if (r_lvl > LW'(MAX_LEVEL))     n_state = S_LINE;
                else                                 n_state = S_SPLIT1;
            end
            S_SPLIT1: n_state = S_SPLIT2;
            S_SPLIT2: n_state = S_SPLIT3;
            S_SPLIT3: n_state = S_BOX;
            S_NEXT:   n_state = (r_sp == '0) ? S_COMMIT : S_POP;
            S_POP:    n_state = S_BOX;
            S_COMMIT: n_state = r_final ? S_EMIT : S_TAIL;
            S_TAIL: begin
                if (!r_last)                               n_state = S_IDLE;
                else if (r_started && (r_cuy != r_mvy))    n_state = S_LINE;
                else                                       n_state = S_EMIT;
            end
            S_EMIT:   if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_started = r_started;
        n_err     = r_err;
        n_mvx = r_mvx; n_mvy = r_mvy; n_cux = r_cux; n_cuy = r_cuy;
        n_count = r_count;
        n_tot   = r_tot;
        n_final = r_final;
        n_chord = r_chord;
        n_lx0 = r_lx0; n_ly0 = r_ly0; n_lx1 = r_lx1; n_ly1 = r_ly1;
        n_dir = r_dir; n_dpos = r_dpos;
        n_ma = r_ma; n_acc = r_acc; n_mb = r_mb; n_mc = r_mc; n_me = r_me;
        n_mcnt = r_mcnt;
        n_cubic = r_cubic;
        n_vx = r_vx; n_vy = r_vy; n_tx = r_tx; n_ty = r_ty;
        n_lvl = r_lvl; n_sp = r_sp;
        n_ovalid = r_ovalid;
        n_out = r_out;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        case (r_state)
            S_DISPATCH: begin
                n_tot   = '0;
                n_final = 1'b0;
                n_chord = 1'b0;
                n_lvl   = '0;
                n_sp    = '0;
                if (!r_started && !r_err) begin
                    if (r_func == FN_MOVETO) begin
                        n_started = 1'b1;
                        n_mvx = r_ax; n_cux = r_ax;
                        n_mvy = r_ay; n_cuy = r_ay;
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (r_started) begin
                    if (r_func == FN_LINETO) begin
                        n_lx0 = r_cux; n_ly0 = r_cuy; n_lx1 = r_ax; n_ly1 = r_ay;
                    end else begin
                        n_lx0 = r_cux; n_ly0 = r_cuy; n_lx1 = r_mvx; n_ly1 = r_mvy;
                    end
                    n_cubic = (r_func == FN_CUBICTO);
                    n_vx[0] = r_cux; n_vy[0] = r_cuy;
                    n_vx[1] = r_ax;  n_vy[1] = r_ay;
                    n_vx[2] = r_bx;  n_vy[2] = r_by;
                    n_vx[3] = r_cx;  n_vy[3] = r_cy;
                end
            end
            S_LINE: begin
                n_dir  = (r_ly0 < r_ly1) ? 2'sd1 : -2'sd1;
                n_dpos = (r_ly0 < r_ly1);
                n_ma   = P'(M'(px) - M'(r_lx0));
                n_mb   = M'(r_ly1) - M'(r_ly0);
                n_mc   = M'(py) - M'(r_ly0);
                n_me   = M'(r_lx1) - M'(r_lx0);
                n_acc  = '0;
                n_mcnt = '0;
                if (line_quick) n_tot = r_tot + TW'(line_r);
            end
            S_MUL: begin
                n_acc  = negate ? (r_acc - term) : (r_acc + term);
                n_mcnt = r_mcnt + CW'(1);
                if (r_mcnt == CW'(M - 1)) begin
                    n_ma = P'(r_mc);
                    n_mb = r_me;
                end else begin
                    n_ma = r_ma <<< 1;
                    n_mb = r_mb >> 1;
                end
            end
            S_MRES: begin
                // Crossing when the point lies left of the line, that is when the line passes to its right.
                if (r_dpos ? (r_acc < 0) : (r_acc > 0)) n_tot = r_tot + TW'(r_dir);
            end
            S_BOX: begin
                n_chord = 1'b0;
                if (box_done) begin
                    n_tot = r_tot + TW'(box_r);
                end else if (r_lvl > LW'(MAX_LEVEL)) begin
                    n_chord = 1'b1;
                    n_lx0 = r_vx[0]; n_ly0 = r_vy[0]; n_lx1 = end_x; n_ly1 = end_y;
                end
            end
            S_SPLIT1: begin
                if (r_cubic) begin
                    n_tx[0] = f_half(r_vx[0], r_vx[1]); n_ty[0] = f_half(r_vy[0], r_vy[1]);
                    n_tx[1] = f_half(r_vx[1], r_vx[2]); n_ty[1] = f_half(r_vy[1], r_vy[2]);
                    n_tx[2] = f_half(r_vx[2], r_vx[3]); n_ty[2] = f_half(r_vy[2], r_vy[3]);
                end else begin
                    n_tx[0] = f_half(r_vx[0], r_vx[1]); n_ty[0] = f_half(r_vy[0], r_vy[1]);
                    n_tx[2] = f_half(r_vx[1], r_vx[2]); n_ty[2] = f_half(r_vy[1], r_vy[2]);
                end
            end
            S_SPLIT2: begin
                if (r_cubic) begin
                    n_tx[3] = f_half(r_tx[0], r_tx[1]); n_ty[3] = f_half(r_ty[0], r_ty[1]);
                    n_tx[4] = f_half(r_tx[1], r_tx[2]); n_ty[4] = f_half(r_ty[1], r_ty[2]);
                end else begin
                    n_tx[3] = r_tx[0]; n_ty[3] = r_ty[0];
                    n_tx[4] = r_tx[2]; n_ty[4] = r_ty[2];
                end
            end
            S_SPLIT3: begin
                // Right half goes onto the stack; continue with the left half.
                if (r_cubic) begin
                    n_vx[1] = r_tx[0]; n_vy[1] = r_ty[0];
                    n_vx[2] = r_tx[3]; n_vy[2] = r_ty[3];
                    n_vx[3] = mx;      n_vy[3] = my;
                end else begin
                    n_vx[1] = r_tx[3]; n_vy[1] = r_ty[3];
                    n_vx[2] = mx;      n_vy[2] = my;
                end
                n_lvl = r_lvl + LW'(1);
                n_sp  = r_sp + LW'(1);
            end
            S_NEXT: begin
                if (r_sp != '0) n_sp = sp_m1;
            end
            S_POP: begin
                n_vx[0] = r_rd[FW-1 -: W];
                n_vx[1] = r_rd[FW-1-W -: W];
                n_vx[2] = r_rd[FW-1-2*W -: W];
                n_vx[3] = r_rd[FW-1-3*W -: W];
                n_vy[0] = r_rd[FW-1-4*W -: W];
                n_vy[1] = r_rd[FW-1-5*W -: W];
                n_vy[2] = r_rd[FW-1-6*W -: W];
                n_vy[3] = r_rd[FW-1-7*W -: W];
                n_lvl   = r_rd[LW-1:0];
            end
            S_COMMIT: begin
                n_count = cnt_sat;
                if (!r_final) begin
                    case (r_func)
                        FN_MOVETO: begin
                            n_mvx = r_ax; n_cux = r_ax;
                            n_mvy = r_ay; n_cuy = r_ay;
                        end
                        FN_LINETO:  begin n_cux = r_ax; n_cuy = r_ay; end
                        FN_QUADTO:  begin n_cux = r_bx; n_cuy = r_by; end
                        FN_CUBICTO: begin n_cux = r_cx; n_cuy = r_cy; end
                        FN_CLOSE:   begin n_cux = r_mvx; n_cuy = r_mvy; end
                        default:    n_cux = r_cux;
                    endcase
                end
            end
            S_TAIL: begin
                n_final = 1'b1;
                n_chord = 1'b0;
                n_tot   = '0;
                n_lx0 = r_cux; n_ly0 = r_cuy; n_lx1 = r_mvx; n_ly1 = r_mvy;
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    if (!r_started)          n_out.winding = '0;
                    else if (cnt_w > OUT_HI) n_out.winding = OUT_HI[15:0];
                    else if (cnt_w < OUT_LO) n_out.winding = OUT_LO[15:0];
                    else                     n_out.winding = cnt_w[15:0];
                    n_out.bad_start = r_err;
                    n_started = 1'b0;
                    n_err     = 1'b0;
                    n_mvx = '0; n_mvy = '0; n_cux = '0; n_cuy = '0;
                    n_count = '0;
                end
            end
            default: n_lvl = r_lvl;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        o_out_valid = r_ovalid;
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SPLIT3) mem[r_sp[AW-1:0]] <= push_frame;
        r_rd <= mem[sp_m1[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_px32    <= '0;
            r_py32    <= '0;
            r_started <= 1'b0;
            r_err     <= 1'b0;
            r_mvx <= '0; r_mvy <= '0; r_cux <= '0; r_cuy <= '0;
            r_count   <= '0;
            r_final   <= 1'b0;
            r_chord   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_lvl     <= '0;
            r_sp      <= '0;
            r_mcnt    <= '0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_POINT_X) r_px32 <= i_cfg_data;
                if (i_cfg_index == CFG_POINT_Y) r_py32 <= i_cfg_data;
            end
            r_started <= n_started;
            r_err     <= n_err;
            r_mvx <= n_mvx; r_mvy <= n_mvy; r_cux <= n_cux; r_cuy <= n_cuy;
            r_count   <= n_count;
            r_final   <= n_final;
            r_chord   <= n_chord;
            r_ovalid  <= n_ovalid;
            r_lvl     <= n_lvl;
            r_sp      <= n_sp;
            r_mcnt    <= n_mcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_in.func;
            r_last <= i_in.last_segment;
            r_ax <= f_coord(i_in.ax); r_ay <= f_coord(i_in.ay);
            r_bx <= f_coord(i_in.bx); r_by <= f_coord(i_in.by);
            r_cx <= f_coord(i_in.cx); r_cy <= f_coord(i_in.cy);
        end
        r_tot <= n_tot;
        r_lx0 <= n_lx0; r_ly0 <= n_ly0; r_lx1 <= n_lx1; r_ly1 <= n_ly1;
        r_dir <= n_dir; r_dpos <= n_dpos;
        r_ma <= n_ma; r_acc <= n_acc; r_mb <= n_mb; r_mc <= n_mc; r_me <= n_me;
        r_cubic <= n_cubic;
        r_vx <= n_vx; r_vy <= n_vy; r_tx <= n_tx; r_ty <= n_ty;
        r_out <= n_out;
    end

endmodule
